FILE: rtl/gamepad_report_deframer_core_assert.svh
// Assertion macros used by the deframer port checker
`ifndef GAMEPAD_REPORT_DEFRAMER_CORE_ASSERT_SVH
`define GAMEPAD_REPORT_DEFRAMER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset
`define GPRD_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("deframer check failed");

// Next-cycle implication, sampled on clock, off during reset
`define GPRD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("deframer check failed");

`endif

FILE: rtl/gprd_pkg.sv
// Shared constants, codes and types of the report deframer
package gprd_pkg;

   localparam int BUFFER_BYTES = 16;
   localparam int POS_BITS     = $clog2(BUFFER_BYTES);

   localparam int NUM_BUTTONS  = 4;
   localparam int ID_POS       = 2;
   localparam int CODE_POS     = 3;
   localparam int AXIS_X_POS   = 4;
   localparam int AXIS_Y_POS   = 5;

   typedef logic [7:0] csr_idx_type;
   localparam csr_idx_type CSR_BUTTON_ID = 8'd0;
   localparam csr_idx_type CSR_ANALOG_ID = 8'd1;

   typedef enum logic [1:0] {
      KIND_BUTTON = 2'd0,
      KIND_ANALOG = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   // Results raised by one transfer, drained one per cycle by the emitter while rsp_ch does not stall
   typedef struct packed {
      kind_type                 kind;
      logic [NUM_BUTTONS-1:0]   pending;
      logic [NUM_BUTTONS-1:0]   mask;
      logic signed [7:0]        axis_x;
      logic signed [7:0]        axis_y;
   } job_type;

   typedef struct packed {
      kind_type          kind;
      logic [1:0]        button;
      logic              pressed;
      logic signed [7:0] axis_x;
      logic signed [7:0] axis_y;
      logic              last;
   } rsp_type;

endpackage

FILE: rtl/gprd_if.sv
// Channel interfaces: byte input, result output and register writes
interface gprd_req_if ();
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       chunk_end;
   modport source (output valid, output rx_byte, output chunk_end, input ready);
   modport sink (input valid, input rx_byte, input chunk_end, output ready);
endinterface

interface gprd_rsp_if import gprd_pkg::*; ();
   logic              valid;
   logic              ready;
   kind_type          kind;
   logic [1:0]        button;
   logic              pressed;
   logic signed [7:0] axis_x;
   logic signed [7:0] axis_y;
   logic              last;
   modport source (output valid, output kind, output button, output pressed,
                   output axis_x, output axis_y, output last, input ready);
   modport sink (input valid, input kind, input button, input pressed,
                 input axis_x, input axis_y, input last, output ready);
endinterface

interface gprd_csr_if import gprd_pkg::*; ();
   logic        valid;
   logic        ready;
   csr_idx_type index;
   logic [7:0]  wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

FILE: rtl/gprd_emit.sv
// Result emitter: holds one pending job and serializes it into the output register
module gprd_emit import gprd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        job_load,
   input  job_type     job,
   output logic        job_ready,
   gprd_rsp_if.source  rsp_ch
);

   logic    job_valid_ff, job_valid_in;
   job_type job_ff, job_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic                   slot_free;
   logic                   emit;
   logic                   job_done;
   logic [NUM_BUTTONS-1:0] pick;
   logic [1:0]             pick_idx;
   rsp_type                cur;

   // Lowest pending button first
   always_comb begin
      pick     = '0;
      pick_idx = '0;
      for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
         if (job_ff.pending[i]) begin
            pick     = '0;
            pick[i]  = 1'b1;
            pick_idx = 2'(i);
         end
      end
   end

   always_comb begin
      cur.kind    = job_ff.kind;
      cur.button  = '0;
      cur.pressed = 1'b0;
      cur.axis_x  = job_ff.axis_x;
      cur.axis_y  = job_ff.axis_y;
      cur.last    = 1'b1;
      if (job_ff.kind == KIND_BUTTON) begin
         cur.button  = pick_idx;
         cur.pressed = job_ff.mask[pick_idx];
         cur.last    = (job_ff.pending & ~pick) == '0;
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign emit      = job_valid_ff && slot_free;
   assign job_done  = emit && cur.last;
   assign job_ready = !job_valid_ff || job_done;

   always_comb begin
      job_valid_in = job_valid_ff;
      job_in       = job_ff;
      if (job_load) begin
         job_valid_in = 1'b1;
         job_in       = job;
      end else if (job_done) begin
         job_valid_in = 1'b0;
      end else if (emit) begin
         job_in.pending = job_ff.pending & ~pick;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = cur;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff <= job_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.kind    = rsp_ff.kind;
   assign rsp_ch.button  = rsp_ff.button;
   assign rsp_ch.pressed = rsp_ff.pressed;
   assign rsp_ch.axis_x  = rsp_ff.axis_x;
   assign rsp_ch.axis_y  = rsp_ff.axis_y;
   assign rsp_ch.last    = rsp_ff.last;

endmodule

FILE: rtl/gamepad_report_deframer_core.sv
// Top level: byte deframer with report decode and result emitter
//
//   channel  | dir | transfer carries
//   ---------+-----+----------------------------------------------
//   req_ch   | in  | rx_byte, chunk_end (chunk_end is not decoded)
//   rsp_ch   | out | kind, button, pressed, axis_x, axis_y, last
//   csr_ch   | in  | index, wdata (report id registers)
//
// A byte is decoded in the cycle it is taken and its job is registered at that edge;
// results then pass one at a time through the output register, one per cycle while
// rsp_ch does not stall. A byte that completes a button report with more than one changed
// button holds req_ch.ready low while the job register drains; with no stall on rsp_ch
// every other byte is taken back to back.
// Synchronous reset clears the packet buffer, counters, button state and halt flag.
// A stall on rsp_ch backs up through the job register into req_ch.ready.
module gamepad_report_deframer_core import gprd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   gprd_req_if.sink   req_ch,
   gprd_rsp_if.source rsp_ch,
   gprd_csr_if.sink   csr_ch
);

   logic [7:0]          button_id_ff, button_id_in;
   logic [7:0]          analog_id_ff, analog_id_in;
   logic [7:0]          store_ff [BUFFER_BYTES];
   logic [7:0]          store_in [BUFFER_BYTES];
   logic [POS_BITS-1:0] fill_ff, fill_in;
   logic [POS_BITS-1:0] len_ff, len_in;
   logic [NUM_BUTTONS-1:0] buttons_ff, buttons_in;
   logic                halted_ff, halted_in;

   logic                   accept;
   logic                   take;
   logic [7:0]             rx;
   logic                   start;
   logic                   oversize;
   logic [POS_BITS-1:0]    packet_len;
   logic                   complete;
   logic [7:0]             view [ID_POS:ID_POS+NUM_BUTTONS];
   logic [NUM_BUTTONS-1:0] mask;
   logic [NUM_BUTTONS-1:0] changed;
   logic                   is_button;
   logic                   is_analog;
   logic                   job_load;
   logic                   job_ready;
   job_type                job;

   assign rx       = req_ch.rx_byte;
   assign accept   = req_ch.valid && req_ch.ready;
   assign take     = accept && !halted_ff;
   assign start    = fill_ff == '0;
   assign oversize = start && ({1'b0, rx} >= 9'(BUFFER_BYTES));
   assign packet_len = start ? rx[POS_BITS-1:0] : len_ff;
   assign complete = !oversize && (fill_ff == packet_len);

   // Header and code bytes as they stand once this byte is written
   always_comb begin
      for (int k = ID_POS; k <= ID_POS + NUM_BUTTONS; k++) begin
         view[k] = (fill_ff == POS_BITS'(k)) ? rx : store_ff[k];
      end
   end

   // Build the pressed mask; a code of 4 or more ends the list
   always_comb begin
      logic stop;
      stop = 1'b0;
      mask = '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         if (!stop) begin
            if (view[CODE_POS+i] >= 8'(NUM_BUTTONS)) begin
               stop = 1'b1;
            end else begin
               mask[view[CODE_POS+i][1:0]] = 1'b1;
            end
         end
      end
   end

   assign changed   = mask ^ buttons_ff;
   assign is_button = view[ID_POS] == button_id_ff;
   assign is_analog = !is_button && (view[ID_POS] == analog_id_ff);

   always_comb begin
      job_load    = 1'b0;
      job.kind    = KIND_BUTTON;
      job.pending = changed;
      job.mask    = mask;
      job.axis_x  = '0;
      job.axis_y  = '0;
      if (take) begin
         if (oversize) begin
            job_load    = 1'b1;
            job.kind    = KIND_ERROR;
            job.pending = '0;
            job.mask    = '0;
         end else if (complete && is_button) begin
            job_load = changed != '0;
         end else if (complete && is_analog) begin
            job_load    = 1'b1;
            job.kind    = KIND_ANALOG;
            job.pending = '0;
            job.mask    = '0;
            job.axis_x  = view[AXIS_X_POS];
            job.axis_y  = view[AXIS_Y_POS];
         end
      end
   end

   always_comb begin
      store_in   = store_ff;
      fill_in    = fill_ff;
      len_in     = len_ff;
      buttons_in = buttons_ff;
      halted_in  = halted_ff;
      if (take) begin
         if (oversize) begin
            halted_in = 1'b1;
         end else begin
            store_in[fill_ff] = rx;
            len_in            = packet_len;
            fill_in           = complete ? '0 : fill_ff + POS_BITS'(1);
            if (complete && is_button) begin
               buttons_in = mask;
            end
         end
      end
   end

   always_comb begin
      button_id_in = button_id_ff;
      analog_id_in = analog_id_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            CSR_BUTTON_ID: button_id_in = csr_ch.wdata;
            CSR_ANALOG_ID: analog_id_in = csr_ch.wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         button_id_ff <= 8'd7;
         analog_id_ff <= 8'd8;
         for (int k = 0; k < BUFFER_BYTES; k++) begin
            store_ff[k] <= '0;
         end
         fill_ff    <= '0;
         len_ff     <= '0;
         buttons_ff <= '0;
         halted_ff  <= 1'b0;
      end else begin
         button_id_ff <= button_id_in;
         analog_id_ff <= analog_id_in;
         store_ff     <= store_in;
         fill_ff      <= fill_in;
         len_ff       <= len_in;
         buttons_ff   <= buttons_in;
         halted_ff    <= halted_in;
      end
   end

   assign req_ch.ready = job_ready;
   assign csr_ch.ready = 1'b1;

   gprd_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .job_load  (job_load),
      .job       (job),
      .job_ready (job_ready),
      .rsp_ch    (rsp_ch)
   );

endmodule

FILE: rtl/gprd_chk.sv
// Port checker for the deframer top level, attached by bind
`include "gamepad_report_deframer_core_assert.svh"

module gprd_chk import gprd_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [1:0]        rsp_kind,
   input logic [1:0]        rsp_button,
   input logic              rsp_pressed,
   input logic signed [7:0] rsp_axis_x,
   input logic signed [7:0] rsp_axis_y,
   input logic              rsp_last
);

   logic        is_error;
   logic        is_analog;
   logic        error_clean;
   logic [21:0] rsp_word;

   assign is_error  = rsp_valid && (rsp_kind == KIND_ERROR);
   assign is_analog = rsp_valid && (rsp_kind == KIND_ANALOG);
   assign rsp_word  = {rsp_kind, rsp_button, rsp_pressed, rsp_axis_x, rsp_axis_y, rsp_last};
   assign error_clean = rsp_button == 2'd0 && !rsp_pressed && rsp_axis_x == 8'sd0
                        && rsp_axis_y == 8'sd0 && rsp_last;

   // Hold a stalled result
   `GPRD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))

   `GPRD_ASSERT_SAME(a_error_fields, is_error, error_clean)

   // Halt: nothing follows the error transfer
   `GPRD_ASSERT_NEXT(a_error_final, is_error && rsp_ready, !rsp_valid)

   `GPRD_ASSERT_SAME(a_analog_single, is_analog, rsp_last && rsp_button == 2'd0 && !rsp_pressed)

endmodule

bind gamepad_report_deframer_core gprd_chk u_chk (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_kind    (rsp_ch.kind),
   .rsp_button  (rsp_ch.button),
   .rsp_pressed (rsp_ch.pressed),
   .rsp_axis_x  (rsp_ch.axis_x),
   .rsp_axis_y  (rsp_ch.axis_y),
   .rsp_last    (rsp_ch.last)
);

FILE: tb/tb_gamepad_report_deframer_core.sv
// Testbench for the report deframer: directed table, random packets, scoreboard check
`timescale 1ns / 1ps

module tb_gamepad_report_deframer_core import gprd_pkg::*; ();

   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASE_BYTES   = 48;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 20;
   localparam int HOLD_CYCLES   = 400;
   localparam int HOLD_AFTER    = 25;

   localparam csr_idx_type CSR_SPARE_IDX = CSR_ANALOG_ID + 8'd1;
   localparam csr_idx_type CSR_TOP_IDX   = 8'hFF;

   typedef struct packed {
      logic [7:0] data;
      logic       chunk;
      logic       typed;
      rsp_type    want;
   } stim_row_type;

   localparam rsp_type NO_RESULT = '0;
   localparam rsp_type ANALOG_EXTREMES =
      '{KIND_ANALOG, 2'd0, 1'b0, 8'sh80, 8'sh7F, 1'b1};
   localparam rsp_type OVERSIZE_ERROR =
      '{KIND_ERROR, 2'd0, 1'b0, 8'sh00, 8'sh00, 1'b1};

   // Default ids: button report 7, analog report 8
   localparam stim_row_type OPENING_ROWS [24] = '{
      // zero length byte: complete at once, id read from a cleared store
      '{8'h00, 1'b1, 1'b0, NO_RESULT},
      // analog report right after reset, axis extremes
      '{8'h05, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b1, 1'b0, NO_RESULT},
      '{8'h08, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h80, 1'b0, 1'b0, NO_RESULT},
      '{8'h7F, 1'b1, 1'b1, ANALOG_EXTREMES},
      // press all four buttons
      '{8'h06, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 1'b0, NO_RESULT},
      '{8'h07, 1'b1, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h01, 1'b0, 1'b0, NO_RESULT},
      '{8'h02, 1'b1, 1'b0, NO_RESULT},
      '{8'h03, 1'b0, 1'b0, NO_RESULT},
      // short button report: stale codes give the same mask, nothing changes
      '{8'h02, 1'b1, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 1'b0, NO_RESULT},
      '{8'h07, 1'b0, 1'b0, NO_RESULT},
      // code 4 ends the list at once: release everything
      '{8'h03, 1'b0, 1'b0, NO_RESULT},
      '{8'h55, 1'b1, 1'b0, NO_RESULT},
      '{8'h07, 1'b0, 1'b0, NO_RESULT},
      '{8'h04, 1'b1, 1'b0, NO_RESULT},
      // short analog report: axes come from stale store bytes
      '{8'h02, 1'b0, 1'b0, NO_RESULT},
      '{8'hAA, 1'b0, 1'b0, NO_RESULT},
      '{8'h08, 1'b1, 1'b0, NO_RESULT}
   };

   // Oversize length halts the block; everything after it is dropped
   localparam stim_row_type CLOSING_ROWS [4] = '{
      '{8'h10, 1'b0, 1'b1, OVERSIZE_ERROR},
      '{8'hFF, 1'b1, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h03, 1'b1, 1'b0, NO_RESULT}
   };

   logic clock;
   logic reset;

   gprd_req_if req_ch ();
   gprd_rsp_if rsp_ch ();
   gprd_csr_if csr_ch ();

   gamepad_report_deframer_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Shadow of the block state
   logic [7:0] store_copy [BUFFER_BYTES] = '{default: 8'h00};
   logic [8:0] fill_pos     = '0;
   logic [8:0] frame_len    = '0;
   logic [3:0] buttons_copy = '0;
   logic       halted_copy  = 1'b0;
   logic [7:0] button_id    = 8'd7;
   logic [7:0] analog_id    = 8'd8;

   rsp_type byte_events [$];
   rsp_type owed_events [$];

   int  mismatches   = 0;
   int  events_seen  = 0;
   int  phase_bytes  = 0;
   bit  sender_idles = 1'b1;
   bit  quiet_tail   = 1'b0;
   bit  held_off     = 1'b0;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic logic [7:0] stored_byte(input int idx);
      return (idx < BUFFER_BYTES) ? store_copy[idx] : 8'h00;
   endfunction

   // Events caused by one stream byte, left in byte_events
   function automatic void deframe_byte(input logic [7:0] rx);
      logic [3:0] pressed_now;
      logic [3:0] flipped;
      logic [7:0] id_byte;
      logic [7:0] code;
      bit         ended;
      rsp_type    ev;
      byte_events.delete();
      if (halted_copy) return;
      if (fill_pos == 9'd0) begin
         frame_len = {1'b0, rx} + 9'd1;
         if (frame_len > BUFFER_BYTES) begin
            halted_copy = 1'b1;
            byte_events.push_back(OVERSIZE_ERROR);
            return;
         end
      end
      if (fill_pos < BUFFER_BYTES) store_copy[fill_pos[POS_BITS-1:0]] = rx;
      fill_pos = fill_pos + 9'd1;
      if (fill_pos != frame_len) return;
      fill_pos = '0;
      id_byte = stored_byte(ID_POS);
      if (id_byte == button_id) begin
         pressed_now = '0;
         ended = 1'b0;
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            code = stored_byte(CODE_POS + i);
            if (code >= NUM_BUTTONS) ended = 1'b1;
            if (!ended) pressed_now[code[1:0]] = 1'b1;
         end
         flipped = pressed_now ^ buttons_copy;
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            if (flipped[i]) begin
               ev = '0;
               ev.kind = KIND_BUTTON;
               ev.button = i[1:0];
               ev.pressed = pressed_now[i];
               byte_events.push_back(ev);
            end
         end
         if (byte_events.size() > 0) byte_events[byte_events.size()-1].last = 1'b1;
         buttons_copy = pressed_now;
      end else if (id_byte == analog_id) begin
         ev = '0;
         ev.kind = KIND_ANALOG;
         ev.axis_x = stored_byte(AXIS_X_POS);
         ev.axis_y = stored_byte(AXIS_Y_POS);
         ev.last = 1'b1;
         byte_events.push_back(ev);
      end
   endfunction

   // Offer one byte; on transfer, queue what it owes (typed value if given)
   task automatic offer_byte(input logic [7:0] data, input logic chunk,
                             input logic typed, input rsp_type want);
      if (sender_idles && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.rx_byte   <= data;
      req_ch.chunk_end <= chunk;
      do @(posedge clock); while (!req_ch.ready);
      deframe_byte(data);
      if (typed) begin
         owed_events.push_back(want);
      end else begin
         foreach (byte_events[i]) owed_events.push_back(byte_events[i]);
      end
   endtask

   // Write a report id register once the block has gone quiet
   task automatic write_report_id(input csr_idx_type idx, input logic [7:0] value);
      req_ch.valid <= 1'b0;
      while (owed_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.wdata <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      if (idx == CSR_BUTTON_ID) begin
         button_id = value;
      end else if (idx == CSR_ANALOG_ID) begin
         analog_id = value;
      end
   endtask

   // One complete packet: mostly well-formed reports, some short frames and frames with a random id
   task automatic offer_random_report();
      logic [7:0] frame [16];
      int         len;
      int         pick;
      bit         is_button;
      pick = $urandom_range(0, 99);
      is_button = (pick < 45);
      sender_idles = !quiet_tail && ($urandom_range(0, 3) != 0);
      if (pick >= 90) begin
         len = $urandom_range(0, 2);
      end else if ($urandom_range(0, 7) == 0) begin
         len = $urandom_range(0, 1) ? 15 : $urandom_range(8, 14);
      end else begin
         len = $urandom_range(2, 7);
      end
      frame[0] = len[7:0];
      frame[1] = 8'($urandom_range(0, 255));
      if (pick < 45) begin
         frame[2] = button_id;
      end else if (pick < 75) begin
         frame[2] = analog_id;
      end else begin
         frame[2] = 8'($urandom_range(0, 255));
      end
      for (int i = 3; i < 16; i++) begin
         if (is_button && i < CODE_POS + NUM_BUTTONS) begin
            frame[i] = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(4, 255))
                                                   : 8'($urandom_range(0, 3));
         end else begin
            frame[i] = 8'($urandom_range(0, 255));
         end
      end
      for (int i = 0; i <= len; i++) begin
         offer_byte(frame[i], 1'($urandom_range(0, 1)), 1'b0, NO_RESULT);
      end
      phase_bytes += len + 1;
   endtask

   // Result receiver: random stalls, one long hold-off, none in the tail
   initial begin
      int span;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!held_off && events_seen >= HOLD_AFTER) begin
            held_off = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         span = ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(1, 24);
         repeat (span) @(posedge clock);
      end
   end

   // Check each result transfer against the oldest owed event
   always @(posedge clock) begin : result_check
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.kind, rsp_ch.button, rsp_ch.pressed,
                 rsp_ch.axis_x, rsp_ch.axis_y, rsp_ch.last};
         events_seen++;
         if (owed_events.size() == 0) begin
            mismatches++;
            $display("%0t unexpected result: expected none", $time);
            $display("%0t   actual kind %0d btn %0d prs %0d x %0d y %0d last %0d",
                     $time, got.kind, got.button, got.pressed, got.axis_x, got.axis_y,
                     got.last);
         end else begin
            want = owed_events.pop_front();
            if (got !== want) begin
               mismatches++;
               $display("%0t mismatch: expected kind %0d btn %0d prs %0d x %0d y %0d last %0d",
                        $time, want.kind, want.button, want.pressed, want.axis_x,
                        want.axis_y, want.last);
               $display("%0t             actual kind %0d btn %0d prs %0d x %0d y %0d last %0d",
                        $time, got.kind, got.button, got.pressed, got.axis_x, got.axis_y,
                        got.last);
            end
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("FAIL gamepad_report_deframer_core");
      $finish;
   end

   initial begin
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.rx_byte   <= 8'h00;
      req_ch.chunk_end <= 1'b0;
      csr_ch.valid     <= 1'b0;
      csr_ch.index     <= CSR_BUTTON_ID;
      csr_ch.wdata     <= 8'h00;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (OPENING_ROWS[i]) begin
         offer_byte(OPENING_ROWS[i].data, OPENING_ROWS[i].chunk,
                    OPENING_ROWS[i].typed, OPENING_ROWS[i].want);
      end

      for (int phase = 1; phase <= 5; phase++) begin
         case (phase)
            1: begin
               write_report_id(CSR_BUTTON_ID, 8'hFF);
               write_report_id(CSR_ANALOG_ID, 8'h00);
            end
            2: begin
               write_report_id(CSR_BUTTON_ID, 8'h00);
               write_report_id(CSR_ANALOG_ID, 8'hFF);
            end
            3: begin
               // equal ids: button handling wins
               write_report_id(CSR_BUTTON_ID, 8'h5A);
               write_report_id(CSR_ANALOG_ID, 8'h5A);
            end
            4: begin
               // unmapped indexes must leave both ids alone
               write_report_id(CSR_SPARE_IDX, 8'($urandom_range(0, 255)));
               write_report_id(CSR_TOP_IDX, 8'($urandom_range(0, 255)));
               write_report_id(CSR_BUTTON_ID, 8'($urandom_range(0, 255)));
               write_report_id(CSR_ANALOG_ID, 8'($urandom_range(0, 255)));
            end
            default: begin
               quiet_tail = 1'b1;
               write_report_id(CSR_BUTTON_ID, 8'd7);
               write_report_id(CSR_ANALOG_ID, 8'd8);
            end
         endcase
         phase_bytes = 0;
         while (phase_bytes < PHASE_BYTES) offer_random_report();
      end

      sender_idles = 1'b0;
      foreach (CLOSING_ROWS[i]) begin
         offer_byte(CLOSING_ROWS[i].data, CLOSING_ROWS[i].chunk,
                    CLOSING_ROWS[i].typed, CLOSING_ROWS[i].want);
      end
      req_ch.valid <= 1'b0;

      while (owed_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS gamepad_report_deframer_core");
      end else begin
         $display("FAIL gamepad_report_deframer_core");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/gprd_pkg.sv
rtl/gprd_if.sv
rtl/gprd_emit.sv
rtl/gamepad_report_deframer_core.sv
rtl/gprd_chk.sv
tb/tb_gamepad_report_deframer_core.sv
